>>> design/circular_double_ended_queue_unit_assert.svh
// Assertion macros used by the deque datapath module.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define CDQ_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define CDQ_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> design/cdq_pkg.sv
// Package with constants, codes, types and ring helpers for the deque unit.
`timescale 1ns / 1ps
package cdq_pkg;
   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic fill;
   } ctl_type;

   typedef struct packed {
      logic need_fill;
   } stat_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
   endfunction
endpackage

>>> design/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> design/cdq_ctrl.sv
// Controller state machine sequencing load, execute and refill steps.
`timescale 1ns / 1ps
module cdq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  cdq_pkg::stat_type  stat,
   output cdq_pkg::ctl_type   ctl,
   output logic               busy
);
   import cdq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FILL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.need_fill ? ST_FILL : ST_IDLE;
         end
         ST_FILL: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign ctl.load = start && (state_ff == ST_IDLE);
   assign ctl.exec = (state_ff == ST_EXEC);
   assign ctl.fill = (state_ff == ST_FILL);
endmodule

>>> design/cdq_datapath.sv
// Datapath: ring pointers, count, cached end words, slot RAM and result registers.
`timescale 1ns / 1ps
`include "circular_double_ended_queue_unit_assert.svh"
module cdq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  cdq_pkg::ctl_type                ctl,
   output cdq_pkg::stat_type               stat,
   input  logic [cdq_pkg::CMD_W-1:0]       req_command,
   input  logic [cdq_pkg::VALUE_W-1:0]     req_value,
   output logic                            rsp_strobe,
   output logic [cdq_pkg::VALUE_W-1:0]     rsp_popped_value,
   output logic [cdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cdq_pkg::COUNT_W-1:0]     rsp_count,
   output logic [cdq_pkg::VALUE_W-1:0]     rsp_front_value,
   output logic [cdq_pkg::VALUE_W-1:0]     rsp_back_value
);
   import cdq_pkg::*;

   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [WORD_WIDTH-1:0] front_ff, front_in;
   logic [WORD_WIDTH-1:0] back_ff, back_in;
   logic [WORD_WIDTH-1:0] popped_ff, popped_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  strobe_ff, strobe_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic [IDX_W-1:0]      ram_raddr;
   logic [WORD_WIDTH-1:0] ram_rdata;

   logic empty, full, is_pop;

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign is_pop = (cmd_ff == CMD_POP_FRONT) || (cmd_ff == CMD_POP_BACK);
   assign stat.need_fill = is_pop && (count_ff > CNT_W'(1));

   cdq_ram #(
      .WIDTH(WORD_WIDTH),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(word_ff),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      cmd_in    = cmd_ff;
      word_in   = word_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      strobe_in = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = head_ff;
      ram_raddr = head_ff;

      if (ctl.load) begin
         cmd_in  = req_command;
         word_in = WORD_WIDTH'(req_value);
      end

      if (ctl.exec) begin
         popped_in = '0;
         status_in = STATUS_OK;
         strobe_in = !stat.need_fill;
         unique case (cmd_ff)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  head_in   = idx_prev(head_ff);
                  ram_we    = 1'b1;
                  ram_waddr = head_in;
                  front_in  = word_ff;
                  if (empty) back_in = word_ff;
                  count_in  = count_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  tail_in   = idx_next(tail_ff);
                  ram_we    = 1'b1;
                  ram_waddr = tail_in;
                  back_in   = word_ff;
                  if (empty) front_in = word_ff;
                  count_in  = count_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  popped_in = front_ff;
                  head_in   = idx_next(head_ff);
                  ram_raddr = head_in;
                  count_in  = count_ff - 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     front_in = '0;
                     back_in  = '0;
                  end
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  popped_in = back_ff;
                  tail_in   = idx_prev(tail_ff);
                  ram_raddr = tail_in;
                  count_in  = count_ff - 1'b1;
                  if (count_ff == CNT_W'(1)) begin
                     front_in = '0;
                     back_in  = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      // refill the cached end word from the slot read issued during execute
      if (ctl.fill) begin
         strobe_in = 1'b1;
         if (cmd_ff == CMD_POP_FRONT) begin
            front_in = ram_rdata;
         end else begin
            back_in = ram_rdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= IDX_W'(DEPTH - 1);
         count_ff  <= '0;
         front_ff  <= '0;
         back_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
         strobe_ff <= strobe_in;
      end
      cmd_ff    <= cmd_in;
      word_ff   <= word_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = VALUE_W'(popped_ff);
   assign rsp_status       = status_ff;
   assign rsp_count        = COUNT_W'(count_ff);
   assign rsp_front_value  = VALUE_W'(front_ff);
   assign rsp_back_value   = VALUE_W'(back_ff);

   `CDQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH),
      "deque count exceeds depth")
   `CDQ_ASSERT_ALWAYS(a_empty_ends_zero, !empty || (front_ff == '0 && back_ff == '0),
      "empty deque holds nonzero end words")
   `CDQ_ASSERT_ALWAYS(a_empty_ring, !empty || (tail_ff == idx_prev(head_ff)),
      "empty deque pointers inconsistent")
   `CDQ_ASSERT_NEXT(a_strobe_single, strobe_ff, !strobe_ff,
      "result strobe held for two cycles")
   `CDQ_ASSERT_NEXT(a_load_no_strobe, ctl.load, !strobe_ff,
      "result strobe one cycle after transfer")
endmodule

>>> design/circular_double_ended_queue_unit.sv
// Top level of the circular double-ended queue unit.
//
//   channel   ports                     handshake
//   request   req_command, req_value    start & !busy
//   response  rsp_*                     rsp_strobe, one cycle
//
// A transfer is taken in an idle cycle and executed in the next; busy is high then.
// Pushes, failed commands and pops that empty the deque: result strobe registered from
//   the execute state; the next transfer is taken once the controller is back in idle.
// Pops that leave one or more words: execute, then refill for the slot RAM's registered
//   read that refetches the new front or back word; result strobe registered from refill.
// Synchronous reset empties the deque; the receiver cannot stall results.
`timescale 1ns / 1ps
module circular_double_ended_queue_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cdq_pkg::CMD_W-1:0]     req_command,
   input  logic [cdq_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_strobe,
   output logic [cdq_pkg::VALUE_W-1:0]   rsp_popped_value,
   output logic [cdq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [cdq_pkg::COUNT_W-1:0]   rsp_count,
   output logic [cdq_pkg::VALUE_W-1:0]   rsp_front_value,
   output logic [cdq_pkg::VALUE_W-1:0]   rsp_back_value
);
   import cdq_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   cdq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .stat(stat),
      .ctl(ctl),
      .busy(busy)
   );

   cdq_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .stat(stat),
      .req_command(req_command),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_popped_value(rsp_popped_value),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value)
   );
endmodule
